>>> rtl/core/turtle_bitmap_plotter_unit_defines.svh
// Assertion macros for the turtle bitmap plotter.
`ifndef TURTLE_BITMAP_PLOTTER_UNIT_DEFINES_SVH
`define TURTLE_BITMAP_PLOTTER_UNIT_DEFINES_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define TBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define TBP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/tbp_pkg.sv
// Shared types and defaults of the turtle bitmap plotter.
package tbp_pkg;

  // Default geometry and move limit.
  localparam int TBP_ROWS         = 32;
  localparam int TBP_COLS         = 64;
  localparam int TBP_MAX_DISTANCE = 255;

  // Command codes; every other code is a no-op.
  typedef enum logic [3:0] {
    CMD_PEN_UP   = 4'd1,
    CMD_PEN_DOWN = 4'd2,
    CMD_RIGHT    = 4'd3,
    CMD_LEFT     = 4'd4,
    CMD_MOVE     = 4'd5,
    CMD_READ     = 4'd6
  } cmd_e;

  // Heading, clockwise order.
  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] distance;
    logic [4:0] read_row;
  } cmd_t;

  typedef struct packed {
    logic [63:0] row_bits;
    logic [4:0]  turtle_row;
    logic [5:0]  turtle_col;
    logic [1:0]  turtle_heading;
    logic        pen_is_down;
  } res_t;

endpackage

>>> rtl/core/tbp_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface tbp_cmd_if;
  logic          valid;
  logic          ready;
  tbp_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tbp_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface tbp_res_if;
  logic          valid;
  logic          ready;
  tbp_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tbp_ink_ram.sv
// Single-port bitmap memory, one row per entry, registered read data.
module tbp_ink_ram #(
  parameter int ROWS = tbp_pkg::TBP_ROWS,
  parameter int COLS = tbp_pkg::TBP_COLS,
  localparam int RW  = $clog2(ROWS)
) (
  input  logic            clk_i,
  input  logic [RW-1:0]   addr_i,
  input  logic            re_i,
  input  logic            we_i,
  input  logic [COLS-1:0] wdata_i,
  output logic [COLS-1:0] rdata_o
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/turtle_bitmap_plotter_unit.sv
// Top level of the turtle bitmap plotter: command sequencer around the bitmap memory.

// Turtle command engine over a ROWS x COLS one-bit bitmap held in a single-port
// memory (one row per entry, registered read). Each command item yields exactly
// one result item with the turtle's row, column, heading and pen state after
// the command; row_bits carries the requested row for a read and is zero
// otherwise. After reset the block first sweeps the memory to zero, one row per
// cycle, so it takes no command until the sweep is done. Path per command, from
// acceptance to the result register: pen and turn commands, unknown codes and
// a read of a row out of range go straight to the finish state; a read of a
// row in range waits in the read-wait state for the registered memory data; a
// move walks its steps in the step state, where each pen-down step is a
// read-modify-write of the current row through the single memory port (step
// reads, step_wr writes back). A move ends at the first step that would leave
// the bitmap, so its length is bounded both by the distance and by the bitmap
// edge. Commands are handled one at a time; the next command is taken as soon as
// the sequencer is idle, even while an earlier result still waits to be taken.
`include "turtle_bitmap_plotter_unit_defines.svh"

module turtle_bitmap_plotter_unit #(
  parameter int ROWS         = tbp_pkg::TBP_ROWS,
  parameter int COLS         = tbp_pkg::TBP_COLS,
  parameter int MAX_DISTANCE = tbp_pkg::TBP_MAX_DISTANCE
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tbp_cmd_if.sink  cmd_i,
  tbp_res_if.source res_o
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int SW = $clog2(MAX_DISTANCE + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_STEP_WR,
    S_READ_WAIT,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [RW-1:0]       clr_q, clr_d;
  logic [RW-1:0]       pos_row_q, pos_row_d;
  logic [CW-1:0]       pos_col_q, pos_col_d;
  tbp_pkg::dir_e       head_q, head_d;
  logic                pen_q, pen_d;
  logic [SW-1:0]       steps_q, steps_d;
  logic [COLS-1:0]     bits_q, bits_d;
  logic                res_valid_q, res_valid_d;
  tbp_pkg::res_t       res_q, res_d;

  // memory port
  logic [RW-1:0]       mem_addr;
  logic                mem_re;
  logic                mem_we;
  logic [COLS-1:0]     mem_wdata;
  logic [COLS-1:0]     mem_rdata;

  // next cell in the heading direction
  logic                blocked;
  logic [RW-1:0]       nxt_row;
  logic [CW-1:0]       nxt_col;

  // command decode
  logic                rr_in_range;
  logic [RW-1:0]       rr_addr;
  logic [SW-1:0]       dist_sat;

  tbp_ink_ram #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ink_ram (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    blocked = 1'b0;
    nxt_row = pos_row_q;
    nxt_col = pos_col_q;
    unique case (head_q)
      tbp_pkg::DIR_NORTH: begin
        blocked = (pos_row_q == '0);
        nxt_row = pos_row_q - RW'(1);
      end
      tbp_pkg::DIR_EAST: begin
        blocked = (pos_col_q == CW'(COLS - 1));
        nxt_col = pos_col_q + CW'(1);
      end
      tbp_pkg::DIR_SOUTH: begin
        blocked = (pos_row_q == RW'(ROWS - 1));
        nxt_row = pos_row_q + RW'(1);
      end
      default: begin
        blocked = (pos_col_q == '0);
        nxt_col = pos_col_q - CW'(1);
      end
    endcase
  end

  assign rr_in_range = (32'(cmd_i.data.read_row) < 32'(ROWS));
  assign rr_addr     = RW'(cmd_i.data.read_row);
  // distance saturates at the move limit
  assign dist_sat    = (32'(cmd_i.data.distance) > 32'(MAX_DISTANCE)) ?
                       SW'(MAX_DISTANCE) : SW'(cmd_i.data.distance);

  assign cmd_i.ready = (state_q == S_IDLE);

  // Sequencer. Memory port use per state:
  //   clear: write zero at the sweep row
  //   idle: read the requested row for a read command
  //   step: read the current row when the pen is down
  //   step_wr: write the row back with the cell being left set
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_row_d   = pos_row_q;
    pos_col_d   = pos_col_q;
    head_d      = head_q;
    pen_d       = pen_q;
    steps_d     = steps_q;
    bits_d      = bits_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;
    mem_addr    = pos_row_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = mem_rdata | (COLS'(1) << pos_col_q);

    unique case (state_q)
      S_CLEAR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (clr_q == RW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + RW'(1);
        end
      end

      S_IDLE: begin
        mem_addr = rr_addr;
        if (cmd_i.valid) begin
          bits_d  = '0;
          state_d = S_FINISH;
          unique case (tbp_pkg::cmd_e'(cmd_i.data.mode))
            tbp_pkg::CMD_PEN_UP:   pen_d  = 1'b0;
            tbp_pkg::CMD_PEN_DOWN: pen_d  = 1'b1;
            tbp_pkg::CMD_RIGHT:    head_d = tbp_pkg::dir_e'(head_q + 2'd1);
            tbp_pkg::CMD_LEFT:     head_d = tbp_pkg::dir_e'(head_q + 2'd3);
            tbp_pkg::CMD_MOVE: begin
              steps_d = dist_sat;
              state_d = S_STEP;
            end
            tbp_pkg::CMD_READ: begin
              if (rr_in_range) begin
                mem_re  = 1'b1;
                state_d = S_READ_WAIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_STEP: begin
        // a blocked step ends the move: heading cannot change meanwhile
        if (steps_q == '0 || blocked) begin
          state_d = S_FINISH;
        end else if (pen_q) begin
          mem_re  = 1'b1;
          state_d = S_STEP_WR;
        end else begin
          pos_row_d = nxt_row;
          pos_col_d = nxt_col;
          steps_d   = steps_q - SW'(1);
        end
      end

      S_STEP_WR: begin
        mem_we    = 1'b1;
        pos_row_d = nxt_row;
        pos_col_d = nxt_col;
        steps_d   = steps_q - SW'(1);
        state_d   = S_STEP;
      end

      S_READ_WAIT: begin
        bits_d  = mem_rdata;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // hold here while an earlier result is still stalled downstream
        if (!res_valid_q || res_o.ready) begin
          res_valid_d          = 1'b1;
          res_d.row_bits       = 64'(bits_q);
          res_d.turtle_row     = 5'(pos_row_q);
          res_d.turtle_col     = 6'(pos_col_q);
          res_d.turtle_heading = head_q;
          res_d.pen_is_down    = pen_q;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_row_q   <= '0;
      pos_col_q   <= '0;
      head_q      <= tbp_pkg::DIR_SOUTH;
      pen_q       <= 1'b0;
      steps_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pos_row_q   <= pos_row_d;
      pos_col_q   <= pos_col_d;
      head_q      <= head_d;
      pen_q       <= pen_d;
      steps_q     <= steps_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload and row buffer
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    res_q  <= res_d;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  `TBP_ASSERT(a_pos_in_bounds, (32'(pos_row_q) < 32'(ROWS)) && (32'(pos_col_q) < 32'(COLS)), "turtle outside bitmap")
  `TBP_ASSERT_NEVER(a_ink_pen_up, mem_we && (state_q != S_CLEAR) && !pen_q, "ink written with pen up")
  `TBP_ASSERT(a_step_count, (state_q == S_STEP_WR) |=> (steps_q == $past(steps_q) - SW'(1)), "step count not decremented")
  `TBP_ASSERT(a_finish_posts, ((state_q == S_FINISH) && (state_d == S_IDLE)) |=> res_valid_q, "finished command posted no result")

endmodule
